// ===== sv/resp_numeric_line_encoder_macros.svh =====
// ---------------------------------------------------------------------------
// resp numeric line encoder assertion macros
// shared property forms for the encoder and its bcd converter
// ---------------------------------------------------------------------------
`ifndef RESP_NUMERIC_LINE_ENCODER_MACROS_SVH
`define RESP_NUMERIC_LINE_ENCODER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define RNE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RNE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rne_pkg.sv =====
// ---------------------------------------------------------------------------
// rne_pkg
// shared widths, mode codes, ascii codes and line prefix tables
// ---------------------------------------------------------------------------
`default_nettype none

package rne_pkg;

  localparam int BIN_W     = 64;
  localparam int DIGITS    = 20;
  localparam int BCD_W     = DIGITS * 4;
  localparam int CNT_W     = $clog2(BIN_W);
  localparam int DIG_CNT_W = $clog2(DIGITS + 1);

  localparam logic [3:0] MODE_INT       = 4'd0;
  localparam logic [3:0] MODE_ARRAY     = 4'd1;
  localparam logic [3:0] MODE_MAP       = 4'd2;
  localparam logic [3:0] MODE_SET       = 4'd3;
  localparam logic [3:0] MODE_PUSH      = 4'd4;
  localparam logic [3:0] MODE_BULK      = 4'd5;
  localparam logic [3:0] MODE_VERB      = 4'd6;
  localparam logic [3:0] MODE_NULL      = 4'd7;
  localparam logic [3:0] MODE_BOOL      = 4'd8;
  localparam logic [3:0] MODE_NULL_ARR  = 4'd9;
  localparam logic [3:0] MODE_NULL_BULK = 4'd10;
  localparam logic [3:0] MODE_CRLF      = 4'd11;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef struct packed {
    logic             start;
    logic [BIN_W-1:0] mag;
  } bcd_req_t;

  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
  } bcd_stat_t;

  // bytes ahead of the digits or of cr lf
  function automatic logic [1:0] pre_len(input logic [3:0] mode, input logic flag);
    logic [1:0] len;
    case (mode)
      MODE_INT:       len = flag ? 2'd2 : 2'd1;
      MODE_ARRAY:     len = 2'd1;
      MODE_MAP:       len = 2'd1;
      MODE_SET:       len = 2'd1;
      MODE_PUSH:      len = 2'd1;
      MODE_BULK:      len = 2'd1;
      MODE_VERB:      len = 2'd1;
      MODE_NULL:      len = 2'd1;
      MODE_BOOL:      len = 2'd2;
      MODE_NULL_ARR:  len = 2'd3;
      MODE_NULL_BULK: len = 2'd3;
      default:        len = 2'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] pre_byte(input logic [3:0] mode, input logic flag,
                                          input logic [1:0] idx);
    logic [7:0] b;
    case (mode)
      MODE_INT:       b = (idx == 2'd0) ? CH_COLON : CH_MINUS;
      MODE_ARRAY:     b = CH_STAR;
      MODE_MAP:       b = CH_PCT;
      MODE_SET:       b = CH_TILDE;
      MODE_PUSH:      b = CH_GT;
      MODE_BULK:      b = CH_DOLLAR;
      MODE_VERB:      b = CH_EQ;
      MODE_NULL:      b = CH_UNDER;
      MODE_BOOL:      b = (idx == 2'd0) ? CH_HASH : (flag ? CH_T : CH_F);
      MODE_NULL_ARR:  b = (idx == 2'd0) ? CH_STAR : ((idx == 2'd1) ? CH_MINUS : CH_ONE);
      MODE_NULL_BULK: b = (idx == 2'd0) ? CH_DOLLAR : ((idx == 2'd1) ? CH_MINUS : CH_ONE);
      default:        b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rne_bcd.sv =====
// ---------------------------------------------------------------------------
// rne_bcd
// shift-and-add-3 binary to bcd converter, one input bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

`include "resp_numeric_line_encoder_macros.svh"

module rne_bcd
  import rne_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire bcd_req_t  req,
  output bcd_stat_t      stat
);

  logic [BIN_W-1:0] bin;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] adj;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic             done;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? (bcd[i*4 +: 4] + 4'd3) : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (req.start) begin
      bin     <= req.mag;
      bcd     <= '0;
      cnt     <= '0;
      running <= 1'b1;
      done    <= 1'b0;
    end else if (running) begin
      bcd <= {adj[BCD_W-2:0], bin[BIN_W-1]};
      bin <= {bin[BIN_W-2:0], 1'b0};
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(BIN_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  assign stat.done = done;
  assign stat.bcd  = bcd;

  `RNE_ASSERT_NEXT(a_start_runs, req.start, running && !done, "conversion did not start")
  `RNE_ASSERT_IMPL(a_done_idle, done, !running, "done while still shifting")
  `RNE_ASSERT_NEXT(a_final_shift, running && !req.start && cnt == CNT_W'(BIN_W - 1), done && !running, "conversion did not finish after last bit")

endmodule

`default_nettype wire

// ===== sv/resp_numeric_line_encoder.sv =====
// ---------------------------------------------------------------------------
// resp_numeric_line_encoder
// emits one protocol line per command beat, one byte per strobe
// ---------------------------------------------------------------------------
// first byte is registered in S_PRE, or in S_CR for a bare cr lf line, after
// start is taken in S_IDLE. a token line strobes its prefix bytes, then cr lf.
// a numeric line starts the bcd shifts on start, waits in S_CONV for them, loads
// the digits, skips leading zeros in S_SKIP, strobes digits in S_DIG, then cr lf.
// no new start is taken until busy drops, in the cycle that shows the last byte.
// the receiver cannot stall. rst clears the sequencer and the strobe.
`default_nettype none

`include "resp_numeric_line_encoder_macros.svh"

module resp_numeric_line_encoder
  import rne_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  mode,
  input  wire logic [63:0] value,
  output logic             strobe,
  output logic [7:0]       out_byte,
  output logic             last
);

  typedef enum logic [2:0] {
    S_IDLE, S_PRE, S_CONV, S_SKIP, S_DIG, S_CR, S_LF
  } state_t;

  state_t               state;
  logic [3:0]           mode_r;
  logic                 flag_r;
  logic                 numeric_r;
  logic [1:0]           plen_r;
  logic [1:0]           pidx;
  logic [BCD_W-1:0]     dig;
  logic [DIG_CNT_W-1:0] ndig;

  logic      accept;
  logic      numeric_in;
  logic      flag_in;
  logic [1:0] plen_in;
  bcd_req_t  conv_req;
  bcd_stat_t conv_stat;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign numeric_in = (mode <= MODE_VERB);
  assign flag_in    = (mode == MODE_INT) ? value[63] : (value != 64'd0);
  assign plen_in    = pre_len(mode, flag_in);

  assign conv_req.start = accept && numeric_in;
  assign conv_req.mag   = (mode == MODE_INT && value[63]) ? (~value + 64'd1) : value;

  rne_bcd u_bcd (
    .clk  (clk),
    .rst  (rst),
    .req  (conv_req),
    .stat (conv_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && plen_in != 2'd0) begin
            mode_r    <= mode;
            flag_r    <= flag_in;
            numeric_r <= numeric_in;
            plen_r    <= plen_in;
            pidx      <= 2'd0;
            state     <= S_PRE;
          end else if (accept && mode == MODE_CRLF) begin
            state <= S_CR;
          end
        end
        S_PRE: begin
          strobe   <= 1'b1;
          out_byte <= pre_byte(mode_r, flag_r, pidx);
          pidx     <= pidx + 2'd1;
          if (pidx == plen_r - 2'd1) begin
            state <= numeric_r ? S_CONV : S_CR;
          end
        end
        S_CONV: begin
          if (conv_stat.done) begin
            dig   <= conv_stat.bcd;
            ndig  <= DIG_CNT_W'(DIGITS);
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (dig[BCD_W-1 -: 4] == 4'd0 && ndig != DIG_CNT_W'(1)) begin
            dig  <= {dig[BCD_W-5:0], 4'h0};
            ndig <= ndig - 1'b1;
          end else begin
            state <= S_DIG;
          end
        end
        S_DIG: begin
          strobe   <= 1'b1;
          out_byte <= CH_ZERO + {4'h0, dig[BCD_W-1 -: 4]};
          dig      <= {dig[BCD_W-5:0], 4'h0};
          ndig     <= ndig - 1'b1;
          if (ndig == DIG_CNT_W'(1)) begin
            state <= S_CR;
          end
        end
        S_CR: begin
          strobe   <= 1'b1;
          out_byte <= CH_CR;
          state    <= S_LF;
        end
        S_LF: begin
          strobe   <= 1'b1;
          out_byte <= CH_LF;
          last     <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RNE_ASSERT_IMPL(a_last_frees, strobe && last, !busy, "busy after the last beat")
  `RNE_ASSERT_IMPL(a_mid_busy, strobe && !last, busy, "line ended without a last beat")
  `RNE_ASSERT_NEXT(a_bad_mode, accept && mode > MODE_CRLF, !busy && !strobe, "bad mode output")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// resp_numeric_line_encoder testbench
// drives mode and value beats with bursty start timing, predicts each
// protocol line byte by byte and checks every strobed byte and its last flag
// ---------------------------------------------------------------------------

module testbench;
  import rne_pkg::*;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [3:0]  mode = 4'd0;
  logic [63:0] value = 64'd0;
  logic        busy;
  logic        strobe;
  logic [7:0]  out_byte;
  logic        last;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } line_beat_t;

  class resp_line_scoreboard;
    line_beat_t  line_q[$];
    int unsigned fail_count = 0;

    task report_mismatch(string msg);
      fail_count++;
      $display("mismatch: %s", msg);
    endtask

    function int pending();
      return line_q.size();
    endfunction

    // expected line for one accepted command beat
    function void note_item(logic [3:0] m, logic [63:0] v);
      logic [7:0]  text[$];
      logic [7:0]  digits[$];
      logic [63:0] mag;
      logic [7:0]  lead;
      logic        numeric;
      line_beat_t  b;
      numeric = 1'b0;
      lead = CH_COLON;
      mag = v;
      case (m)
        MODE_INT: begin
          numeric = 1'b1;
          text.push_back(CH_COLON);
          if (v[63]) begin
            text.push_back(CH_MINUS);
            mag = -v;
          end
        end
        MODE_ARRAY, MODE_MAP, MODE_SET, MODE_PUSH, MODE_BULK, MODE_VERB: begin
          numeric = 1'b1;
          case (m)
            MODE_ARRAY: lead = CH_STAR;
            MODE_MAP:   lead = CH_PCT;
            MODE_SET:   lead = CH_TILDE;
            MODE_PUSH:  lead = CH_GT;
            MODE_BULK:  lead = CH_DOLLAR;
            default:    lead = CH_EQ;
          endcase
          text.push_back(lead);
        end
        MODE_NULL: begin
          text.push_back(CH_UNDER);
        end
        MODE_BOOL: begin
          text.push_back(CH_HASH);
          text.push_back((v != 64'd0) ? CH_T : CH_F);
        end
        MODE_NULL_ARR: begin
          text.push_back(CH_STAR);
          text.push_back(CH_MINUS);
          text.push_back(CH_ONE);
        end
        MODE_NULL_BULK: begin
          text.push_back(CH_DOLLAR);
          text.push_back(CH_MINUS);
          text.push_back(CH_ONE);
        end
        MODE_CRLF: begin
        end
        default: return;
      endcase
      if (numeric) begin
        do begin
          digits.push_front(CH_ZERO + 8'(mag % 64'd10));
          mag = mag / 64'd10;
        end while (mag != 64'd0);
        foreach (digits[i]) text.push_back(digits[i]);
      end
      text.push_back(CH_CR);
      text.push_back(CH_LF);
      foreach (text[i]) begin
        b.ch  = text[i];
        b.fin = (i == text.size() - 1);
        line_q.push_back(b);
      end
    endfunction

    task check_result(logic [7:0] got_ch, logic got_fin);
      line_beat_t want;
      if (line_q.size() == 0) begin
        report_mismatch($sformatf("byte %h with nothing expected", got_ch));
        return;
      end
      want = line_q.pop_front();
      if (got_ch !== want.ch)
        report_mismatch($sformatf("out_byte %h, expected %h", got_ch, want.ch));
      if (got_fin !== want.fin)
        report_mismatch($sformatf("last %b, expected %b", got_fin, want.fin));
    endtask
  endclass

  resp_line_scoreboard sb = new();

  resp_numeric_line_encoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .value    (value),
    .strobe   (strobe),
    .out_byte (out_byte),
    .last     (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(out_byte, last);
  end

  // holds start high until the command beat is taken
  task automatic send_item(input logic [3:0] m, input logic [63:0] v);
    start <= 1'b1;
    mode  <= m;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(m, v);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    logic [63:0] p;
    int          k;
    p = 64'd1;
    case ($urandom_range(0, 4))
      0: v = {$urandom(), $urandom()};
      1: v = 64'($urandom_range(0, 999));
      2: v = {$urandom(), $urandom()} >> $urandom_range(0, 63);
      3: begin
        k = $urandom_range(0, 19);
        repeat (k) p = p * 64'd10;
        v = p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      default: v = -({32'd0, $urandom()} >> $urandom_range(0, 31));
    endcase
    return v;
  endfunction

  initial begin
    int          taken;
    int          burst;
    logic [3:0]  m;
    logic        drained_mid;
    taken = 0;
    drained_mid = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed lines
    send_item(MODE_INT, 64'd0);
    send_item(MODE_INT, 64'd1);
    send_item(MODE_INT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(MODE_INT, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(MODE_INT, 64'h8000_0000_0000_0000);
    send_item(MODE_ARRAY, 64'd0);
    send_item(MODE_ARRAY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(MODE_MAP, 64'd10_000_000_000_000_000_000);
    send_item(MODE_SET, 64'd9);
    send_item(MODE_PUSH, 64'd10);
    send_item(MODE_BULK, 64'd123_456_789);
    send_item(MODE_VERB, 64'h8000_0000_0000_0000);
    send_item(MODE_NULL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(MODE_BOOL, 64'd0);
    send_item(MODE_BOOL, 64'd1);
    send_item(MODE_BOOL, 64'h8000_0000_0000_0000);
    send_item(MODE_NULL_ARR, 64'd5);
    send_item(MODE_NULL_BULK, 64'd0);
    send_item(MODE_CRLF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(4'd12, 64'd0);
    send_item(4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(MODE_INT, 64'd0);
    send_item(4'd13, 64'd7);
    send_item(MODE_CRLF, 64'd0);
    wait_drained();

    // random bursts
    while (taken < 196) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        m = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                         : 4'($urandom_range(0, 11));
        send_item(m, random_value());
        taken++;
      end
      if (!drained_mid && taken >= 110) begin
        drained_mid = 1'b1;
        wait_drained();
      end
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(0, 100));
      else idle_cycles($urandom_range(0, 4));
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rne_pkg.sv
sv/rne_bcd.sv
sv/resp_numeric_line_encoder.sv
tb/sv/testbench.sv
